@@ src/fat_directory_entry_scan_macros.svh @@
// Assertion macros shared by the directory entry scanner.
`ifndef FAT_DIRECTORY_ENTRY_SCAN_MACROS_SVH
`define FAT_DIRECTORY_ENTRY_SCAN_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FDES_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define FDES_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/fdes_pkg.sv @@
// Types, constants and codes for the FAT directory entry scanner.
package fdes_pkg;

   localparam logic [7:0] END_MARK       = 8'h00;
   localparam logic [7:0] DELETED_MARK   = 8'hE5;
   localparam logic [7:0] LONG_NAME_ATTR = 8'h0F;
   localparam logic [7:0] VOLUME_BIT     = 8'h08;
   localparam logic [7:0] DIR_BIT        = 8'h10;

   localparam logic [63:0] NAME_BASE_RESET = 64'h2020_2020_2020_2020;
   localparam logic [23:0] NAME_EXT_RESET  = 24'h20_2020;
   localparam logic [15:0] COUNT_MAX       = 16'hFFFF;

   localparam int REQ_DATA_W = 160;
   localparam int RSP_DATA_W = 184;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_IDX_W  = 2;

   typedef enum logic [1:0] {
      ST_SEARCHING = 2'd0,
      ST_FOUND     = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_IGNORED   = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SEARCH_MODE      = 2'd0,
      CSR_TARGET_INDEX     = 2'd1,
      CSR_TARGET_NAME_BASE = 2'd2,
      CSR_TARGET_NAME_EXT  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic        search_mode;
      logic [15:0] target_index;
      logic [63:0] target_name_base;
      logic [23:0] target_name_ext;
   } cfg_type;

   typedef struct packed {
      logic [63:0] name_base;
      logic [23:0] name_ext;
      logic [7:0]  attributes;
      logic [15:0] cluster_high_half;
      logic [15:0] cluster_low_half;
      logic [31:0] size_bytes;
   } entry_type;

   typedef struct packed {
      logic [15:0] visible_count;
      logic        search_done;
   } scan_state_type;

   typedef struct packed {
      status_type  status;
      logic [63:0] found_name_base;
      logic [23:0] found_name_ext;
      logic [7:0]  found_attributes;
      logic        is_directory;
      logic [31:0] first_cluster;
      logic [31:0] found_size;
      logic [15:0] visible_seen;
   } result_type;

endpackage

@@ src/fdes_classify.sv @@
// Per-entry decision: ignore after a decision, skip, count, match or end, and the next scan state.
module fdes_classify (
   input  fdes_pkg::cfg_type        cfg,
   input  logic                     begin_req,
   input  logic                     chain_end,
   input  fdes_pkg::entry_type      entry,
   input  fdes_pkg::scan_state_type cur,
   output fdes_pkg::result_type     result,
   output fdes_pkg::scan_state_type nxt
);

   logic [15:0] count;
   logic        done;
   logic [7:0]  first_byte;
   logic        is_end;
   logic        is_skip;
   logic        match;

   always_comb begin
      // a begin beat clears the scan before it is looked at
      count      = begin_req ? 16'd0 : cur.visible_count;
      done       = begin_req ? 1'b0 : cur.search_done;
      first_byte = entry.name_base[7:0];
      is_end     = chain_end || (first_byte == fdes_pkg::END_MARK);
      is_skip    = (first_byte == fdes_pkg::DELETED_MARK)
                || (entry.attributes == fdes_pkg::LONG_NAME_ATTR)
                || ((entry.attributes & fdes_pkg::VOLUME_BIT) != 8'd0);
      if (cfg.search_mode) begin
         match = (entry.name_base == cfg.target_name_base)
              && (entry.name_ext == cfg.target_name_ext);
      end else begin
         match = (count == cfg.target_index);
      end
   end

   always_comb begin
      nxt.visible_count = count;
      nxt.search_done   = done;
      result            = '0;
      result.status     = fdes_pkg::ST_SEARCHING;
      if (done) begin
         result.status = fdes_pkg::ST_IGNORED;
      end else if (is_end) begin
         nxt.search_done = 1'b1;
         result.status   = fdes_pkg::ST_NOT_FOUND;
      end else if (is_skip) begin
         result.status = fdes_pkg::ST_SEARCHING;
      end else if (match) begin
         nxt.search_done         = 1'b1;
         result.status           = fdes_pkg::ST_FOUND;
         result.found_name_base  = entry.name_base;
         result.found_name_ext   = entry.name_ext;
         result.found_attributes = entry.attributes;
         result.is_directory     = (entry.attributes & fdes_pkg::DIR_BIT) != 8'd0;
         result.first_cluster    = {entry.cluster_high_half, entry.cluster_low_half};
         result.found_size       = entry.size_bytes;
      end else if (count != fdes_pkg::COUNT_MAX) begin
         nxt.visible_count = count + 16'd1;
      end
      result.visible_seen = nxt.visible_count;
   end

endmodule

@@ src/fat_directory_entry_scan.sv @@
// Top level of the FAT directory entry scanner.
//
// Directory entries arrive one per beat on the req_ channel: tdata carries the
// 32-byte entry fields, tuser is begin_req (start a new search) and tlast is
// chain_end (the directory's cluster chain ended, entry fields ignored).
// Every entry beat returns exactly one rsp_ beat: tuser is the status
// (searching, found, not found, ignored after a decision) and tdata carries
// the matched entry fields, zero unless found, plus the visible count.
// The csr_ port sets search mode, target index and target 8.3 name; write it
// only while no beats are in flight.
// One input register, then the compare-and-count logic into the result
// register. Throughput is one entry per cycle while rsp_tready stays high,
// set by the count update on the scan state, which updates with each result.
// When rsp_tready is low the result register holds and the input register
// still takes one more beat; req_tready drops once both are full.
// Synchronous reset clears the search state, the pipeline valids and restores
// the registers to index mode, index 0 and an all-space target name.
`include "fat_directory_entry_scan_macros.svh"

module fat_directory_entry_scan (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // name_base[63:0], name_ext[87:64], attributes[95:88],
   // cluster_high_half[111:96], cluster_low_half[127:112], size_bytes[159:128]
   input  logic [fdes_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                              req_tuser,  // begin_req
   input  logic                              req_tlast,  // chain_end
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // found_name_base[63:0], found_name_ext[87:64], found_attributes[95:88],
   // is_directory[96], first_cluster[128:97], found_size[160:129],
   // visible_seen[176:161], zero fill[183:177]
   output logic [fdes_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic [1:0]                        rsp_tuser,  // status
   input  logic                              csr_we,
   input  logic [fdes_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [fdes_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   fdes_pkg::cfg_type        cfg_ff, cfg_in;
   fdes_pkg::scan_state_type state_ff, state_in;
   fdes_pkg::scan_state_type state_next;
   fdes_pkg::entry_type      entry_ff, entry_in;
   fdes_pkg::result_type     result_ff, result_in;
   fdes_pkg::result_type     result_calc;
   logic                     in_valid_ff, in_valid_in;
   logic                     begin_ff, begin_in;
   logic                     chain_end_ff, chain_end_in;
   logic                     out_valid_ff, out_valid_in;
   logic                     out_free;
   logic                     advance;
   logic                     req_take;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (fdes_pkg::csr_index_type'(csr_index))
            fdes_pkg::CSR_SEARCH_MODE:      cfg_in.search_mode      = csr_wdata[0];
            fdes_pkg::CSR_TARGET_INDEX:     cfg_in.target_index     = csr_wdata[15:0];
            fdes_pkg::CSR_TARGET_NAME_BASE: cfg_in.target_name_base = csr_wdata;
            fdes_pkg::CSR_TARGET_NAME_EXT:  cfg_in.target_name_ext  = csr_wdata[23:0];
            default:                        cfg_in = cfg_ff;
         endcase
      end
   end

   // handshake: result register drains, input register refills behind it
   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign req_take   = req_tvalid && req_tready;

   fdes_classify u_classify (
      .cfg       (cfg_ff),
      .begin_req (begin_ff),
      .chain_end (chain_end_ff),
      .entry     (entry_ff),
      .cur       (state_ff),
      .result    (result_calc),
      .nxt       (state_next)
   );

   always_comb begin
      in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      // tdata has name_base lowest; the struct has it highest
      entry_in     = req_take ? {req_tdata[63:0], req_tdata[87:64], req_tdata[95:88],
                                 req_tdata[111:96], req_tdata[127:112],
                                 req_tdata[159:128]}
                              : entry_ff;
      begin_in     = req_take ? req_tuser : begin_ff;
      chain_end_in = req_take ? req_tlast : chain_end_ff;
      out_valid_in = advance ? 1'b1 : (out_free ? 1'b0 : out_valid_ff);
      result_in    = advance ? result_calc : result_ff;
      state_in     = advance ? state_next : state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.search_mode      <= 1'b0;
         cfg_ff.target_index     <= 16'd0;
         cfg_ff.target_name_base <= fdes_pkg::NAME_BASE_RESET;
         cfg_ff.target_name_ext  <= fdes_pkg::NAME_EXT_RESET;
         state_ff                <= '0;
         in_valid_ff             <= 1'b0;
         out_valid_ff            <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      entry_ff     <= entry_in;
      begin_ff     <= begin_in;
      chain_end_ff <= chain_end_in;
      result_ff    <= result_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = result_ff.status;
   assign rsp_tdata  = {7'd0,
                        result_ff.visible_seen,
                        result_ff.found_size,
                        result_ff.first_cluster,
                        result_ff.is_directory,
                        result_ff.found_attributes,
                        result_ff.found_name_ext,
                        result_ff.found_name_base};

   `FDES_ASSERT_NOW(a_fields_zero_unless_found, clock, reset,
      rsp_tvalid && (rsp_tuser != fdes_pkg::ST_FOUND), rsp_tdata[160:0] == 161'd0,
      "entry fields set on a result that is not a match")

   `FDES_ASSERT_NEXT(a_count_monotonic, clock, reset,
      advance && !begin_ff, state_ff.visible_count >= $past(state_ff.visible_count),
      "visible count dropped without a new search")

   `FDES_ASSERT_NEXT(a_ignored_after_decision, clock, reset,
      advance && state_ff.search_done && !begin_ff,
      rsp_tvalid && (rsp_tuser == fdes_pkg::ST_IGNORED),
      "entry after a decision was not answered as ignored")

endmodule
